@@ hdl/anc_pkg.sv @@
package anc_pkg;

   // Table geometry.
   localparam int ENTRIES     = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int HANDLE_BITS = 8;

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SCNT_W  = IDX_W + 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int HQ_DEPTH = ENTRIES * QUEUE_DEPTH;
   localparam int HQ_AW   = (HQ_DEPTH > 1) ? $clog2(HQ_DEPTH) : 1;

   // Entry states.
   localparam logic [1:0] ST_FREE       = 2'd0;
   localparam logic [1:0] ST_INCOMPLETE = 2'd1;
   localparam logic [1:0] ST_REACHABLE  = 2'd2;

   // Request opcodes.
   localparam logic [1:0] OP_RX      = 2'd0;
   localparam logic [1:0] OP_RESOLVE = 2'd1;
   localparam logic [1:0] OP_LEARN   = 2'd2;

   // Result actions.
   localparam logic [2:0] ACT_RESOLVED = 3'd0;
   localparam logic [2:0] ACT_PENDING  = 3'd1;
   localparam logic [2:0] ACT_FAILED   = 3'd2;
   localparam logic [2:0] ACT_TRANSMIT = 3'd3;
   localparam logic [2:0] ACT_FREE     = 3'd4;
   localparam logic [2:0] ACT_REQUEST  = 3'd5;
   localparam logic [2:0] ACT_REPLY    = 3'd6;

   // Configuration register indexes.
   localparam logic [1:0] REG_OWN_IP       = 2'd0;
   localparam logic [1:0] REG_OWN_IP_VALID = 2'd1;
   localparam logic [1:0] REG_OWN_MAC      = 2'd2;
   localparam logic [1:0] REG_TIMEOUT_MS   = 2'd3;

   localparam logic [15:0] DEFAULT_TIMEOUT = 16'd5000;
   localparam logic [15:0] ARP_HW_ETHERNET = 16'd1;
   localparam logic [15:0] ARP_PROTO_IPV4  = 16'h0800;
   localparam logic [15:0] ARP_OPER_WHO_HAS = 16'd1;
   localparam logic [31:0] BCAST_IP        = 32'hFFFF_FFFF;
   localparam logic [47:0] BCAST_MAC       = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [31:0] rtime;
   } entry_word_type;

   typedef struct packed {
      logic [2:0]  act;
      logic [47:0] mac;
      logic [31:0] ip;
      logic [31:0] src;
      logic [7:0]  handle;
   } res_type;

endpackage

@@ hdl/anc_ram.sv @@
module anc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ hdl/arp_neighbor_cache.sv @@
// IPv4 neighbor cache. Each request is a received ARP packet, a resolve or a learn command,
// and it produces zero to six results on the rsp_ channel, the final one marked by rsp_last.
// The block works on one request at a time and holds req_stall high while it is busy. A
// broadcast or own-address resolve skips the table. Every other request, except a received
// packet that fails the length, hardware-type or protocol check, scans the whole table
// through the entry memory, one entry per cycle, then reads the chosen entry and decides.
// Each released held packet is read from the handle memory and then sent; the other results
// follow from their slots. Output stalls hold the results back. Entry IP, MAC and request
// time live in one memory and the held packet handles in a second; entry state, held counts
// and request-time valid bits are flip-flops that reset clears, so no clearing pass is
// needed. Configuration is always ready.
module arp_neighbor_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_address,
   input  logic [47:0] req_hw_address,
   input  logic [31:0] req_target_address,
   input  logic [15:0] req_arp_operation,
   input  logic [15:0] req_hw_type,
   input  logic [15:0] req_protocol_type,
   input  logic        req_length_ok,
   input  logic        req_has_packet,
   input  logic [7:0]  req_packet_handle,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [47:0] rsp_out_mac,
   output logic [31:0] rsp_out_ip,
   output logic [31:0] rsp_out_src_ip,
   output logic [7:0]  rsp_out_handle,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   localparam int IDX_W  = anc_pkg::IDX_W;
   localparam int SCNT_W = anc_pkg::SCNT_W;
   localparam int CNT_W  = anc_pkg::CNT_W;
   localparam int HQ_AW  = anc_pkg::HQ_AW;
   localparam int HB     = anc_pkg::HANDLE_BITS;
   localparam int EW     = $bits(anc_pkg::entry_word_type);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_ERD    = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_DRD    = 3'd4;
   localparam logic [2:0] S_DWT    = 3'd5;
   localparam logic [2:0] S_SLOT   = 3'd6;

   // Configuration registers.
   logic [31:0] own_ip_ff;
   logic        own_valid_ff;
   logic [47:0] own_mac_ff;
   logic [15:0] timeout_ff;

   // Control state.
   logic [2:0]        fsm_ff, fsm_in;
   logic [SCNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic              cmp_v_ff, cmp_v_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              hit_v_ff, hit_v_in, free_v_ff, free_v_in, reach_v_ff, reach_v_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]  reach_idx_ff, reach_idx_in;
   logic [IDX_W-1:0]  e_ff, e_in;
   logic              ok_ff, ok_in;
   logic [CNT_W-1:0]  k_ff, k_in, drain_n_ff, drain_n_in;
   logic [2:0]        slot_v_ff, slot_v_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Captured request and plan payload.
   logic [1:0]   op_ff, op_in;
   logic [31:0]  addr_ff, addr_in, tgt_ff, tgt_in, now_ff, now_in;
   logic [47:0]  hw_ff, hw_in;
   logic         pkt_ff, pkt_in, reply_ok_ff, reply_ok_in;
   logic [HB-1:0] handle_ff, handle_in;
   logic [2:0]   drain_act_ff, drain_act_in;
   logic [47:0]  drain_mac_ff, drain_mac_in;
   anc_pkg::res_type slot_ff [3];
   anc_pkg::res_type slot_in [3];
   anc_pkg::res_type out_res;
   logic             out_last, out_load, out_free;
   anc_pkg::res_type rsp_ff;
   logic             rsp_last_ff;

   // Per-entry flip-flop state.
   logic [1:0]       st_ff  [anc_pkg::ENTRIES];
   logic             tv_ff  [anc_pkg::ENTRIES];
   logic [CNT_W-1:0] cnt_ff [anc_pkg::ENTRIES];
   logic             st_we, tv_wdata;
   logic [1:0]       st_wdata;
   logic [CNT_W-1:0] cnt_wdata;
   logic [IDX_W-1:0] sel_idx;
   logic [1:0]       st_sel;
   logic             tv_sel;
   logic [CNT_W-1:0] cnt_sel;

   // Memories.
   logic                    er_we;
   logic [IDX_W-1:0]        er_waddr, er_raddr;
   anc_pkg::entry_word_type er_wdata, er_rd;
   logic [EW-1:0]           er_rdata;
   logic                    hq_we;
   logic [HQ_AW-1:0]        hq_waddr, hq_raddr;
   logic [HB-1:0]           hq_wdata, hq_rdata;

   // Decision helpers.
   logic              fresh, cur_tv, expired;
   logic [CNT_W-1:0]  cur_cnt;
   logic [31:0]       elapsed;
   logic [IDX_W-1:0]  pick_idx;
   logic              pick_ok;

   anc_ram #(.WIDTH(EW), .DEPTH(anc_pkg::ENTRIES)) u_entry_ram (
      .clock (clock),
      .we    (er_we),
      .waddr (er_waddr),
      .wdata (er_wdata),
      .raddr (er_raddr),
      .rdata (er_rdata)
   );

   anc_ram #(.WIDTH(HB), .DEPTH(anc_pkg::HQ_DEPTH)) u_held_ram (
      .clock (clock),
      .we    (hq_we),
      .waddr (hq_waddr),
      .wdata (hq_wdata),
      .raddr (hq_raddr),
      .rdata (hq_rdata)
   );

   assign er_rd     = anc_pkg::entry_word_type'(er_rdata);
   assign req_stall = (fsm_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // The per-entry flops are read at one index: the compare slot during the scan and the
   // chosen entry afterwards.
   assign sel_idx = (fsm_ff == S_SCAN) ? cmp_idx_ff : e_ff;
   assign st_sel  = st_ff[sel_idx];
   assign tv_sel  = tv_ff[sel_idx];
   assign cnt_sel = cnt_ff[sel_idx];

   // Allocation order: a matching entry, else the first free one, else the first reachable
   // one, which is evicted.
   assign pick_ok  = hit_v_ff || free_v_ff || reach_v_ff;
   assign pick_idx = hit_v_ff ? hit_idx_ff : (free_v_ff ? free_idx_ff : reach_idx_ff);

   // A freshly allocated entry starts with no held packets and no request time.
   assign fresh   = !hit_v_ff;
   assign cur_cnt = fresh ? '0 : cnt_sel;
   assign cur_tv  = fresh ? 1'b0 : tv_sel;
   assign elapsed = now_ff - er_rd.rtime;
   assign expired = cur_tv && (elapsed > {16'd0, timeout_ff});

   assign hq_raddr = HQ_AW'(e_ff) * HQ_AW'(anc_pkg::QUEUE_DEPTH) + HQ_AW'(k_ff);
   assign hq_waddr = HQ_AW'(e_ff) * HQ_AW'(anc_pkg::QUEUE_DEPTH) + HQ_AW'(cur_cnt);
   assign hq_wdata = handle_ff;

   always_comb begin
      fsm_in       = fsm_ff;
      scan_cnt_in  = scan_cnt_ff;
      cmp_v_in     = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hit_v_in     = hit_v_ff;
      hit_idx_in   = hit_idx_ff;
      free_v_in    = free_v_ff;
      free_idx_in  = free_idx_ff;
      reach_v_in   = reach_v_ff;
      reach_idx_in = reach_idx_ff;
      e_in         = e_ff;
      ok_in        = ok_ff;
      k_in         = k_ff;
      drain_n_in   = drain_n_ff;
      drain_act_in = drain_act_ff;
      drain_mac_in = drain_mac_ff;
      slot_v_in    = slot_v_ff;
      slot_in      = slot_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      tgt_in       = tgt_ff;
      now_in       = now_ff;
      hw_in        = hw_ff;
      pkt_in       = pkt_ff;
      handle_in    = handle_ff;
      reply_ok_in  = reply_ok_ff;
      er_we        = 1'b0;
      er_waddr     = e_ff;
      er_raddr     = e_ff;
      er_wdata     = er_rd;
      hq_we        = 1'b0;
      st_we        = 1'b0;
      st_wdata     = st_sel;
      tv_wdata     = tv_sel;
      cnt_wdata    = cnt_sel;
      out_load     = 1'b0;
      out_res      = slot_ff[2];
      out_last     = 1'b1;

      case (fsm_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_opcode;
               addr_in      = req_address;
               tgt_in       = req_target_address;
               now_in       = req_now_ms;
               hw_in        = req_hw_address;
               pkt_in       = req_has_packet;
               handle_in    = HB'(req_packet_handle);
               reply_ok_in  = (req_arp_operation == anc_pkg::ARP_OPER_WHO_HAS) && own_valid_ff
                              && (req_target_address == own_ip_ff);
               slot_v_in    = '0;
               hit_v_in     = 1'b0;
               free_v_in    = 1'b0;
               reach_v_in   = 1'b0;
               scan_cnt_in  = '0;
               k_in         = '0;
               drain_n_in   = '0;
               slot_in[0]   = '{act: anc_pkg::ACT_FREE, mac: '0, ip: '0, src: '0,
                                handle: 8'(HB'(req_packet_handle))};
               case (req_opcode)
                  anc_pkg::OP_RX: begin
                     if (req_length_ok && (req_hw_type == anc_pkg::ARP_HW_ETHERNET)
                         && (req_protocol_type == anc_pkg::ARP_PROTO_IPV4)) begin
                        fsm_in = S_SCAN;
                     end
                  end
                  anc_pkg::OP_RESOLVE: begin
                     if (req_address == anc_pkg::BCAST_IP) begin
                        slot_v_in[2] = 1'b1;
                        slot_in[2]   = '{act: anc_pkg::ACT_RESOLVED, mac: anc_pkg::BCAST_MAC,
                                         ip: '0, src: '0, handle: '0};
                        fsm_in       = S_DRD;
                     end else if (own_valid_ff && (req_address == own_ip_ff)) begin
                        slot_v_in[0] = req_has_packet;
                        slot_v_in[2] = 1'b1;
                        slot_in[2]   = '{act: anc_pkg::ACT_RESOLVED, mac: own_mac_ff,
                                         ip: '0, src: '0, handle: '0};
                        fsm_in       = S_DRD;
                     end else begin
                        fsm_in = S_SCAN;
                     end
                  end
                  anc_pkg::OP_LEARN: begin
                     fsm_in = S_SCAN;
                  end
                  default: begin
                     fsm_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Read address for the next entry; its compare happens in the following cycle.
            if (scan_cnt_ff < SCNT_W'(anc_pkg::ENTRIES)) begin
               er_raddr    = scan_cnt_ff[IDX_W-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
               cmp_v_in    = 1'b1;
               cmp_idx_in  = scan_cnt_ff[IDX_W-1:0];
            end
            if (cmp_v_ff) begin
               if (!hit_v_ff && (st_sel != anc_pkg::ST_FREE) && (er_rd.ip == addr_ff)) begin
                  hit_v_in   = 1'b1;
                  hit_idx_in = cmp_idx_ff;
               end
               if (!free_v_ff && (st_sel == anc_pkg::ST_FREE)) begin
                  free_v_in   = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (!reach_v_ff && (st_sel == anc_pkg::ST_REACHABLE)) begin
                  reach_v_in   = 1'b1;
                  reach_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == IDX_W'(anc_pkg::ENTRIES - 1)) begin
                  fsm_in = S_ERD;
               end
            end
         end

         S_ERD: begin
            e_in     = pick_idx;
            ok_in    = pick_ok;
            er_raddr = pick_idx;
            fsm_in   = S_DECIDE;
         end

         S_DECIDE: begin
            fsm_in = S_DRD;
            if (op_ff == anc_pkg::OP_RESOLVE) begin
               if (hit_v_ff && (st_sel == anc_pkg::ST_REACHABLE)) begin
                  slot_v_in[2] = 1'b1;
                  slot_in[2]   = '{act: anc_pkg::ACT_RESOLVED, mac: er_rd.mac,
                                   ip: '0, src: '0, handle: '0};
               end else if (!ok_ff) begin
                  slot_v_in[0] = pkt_ff;
                  slot_v_in[2] = 1'b1;
                  slot_in[2]   = '{act: anc_pkg::ACT_FAILED, mac: '0, ip: '0, src: '0,
                                   handle: '0};
               end else if (expired) begin
                  // The request went unanswered: drop everything held and free the entry.
                  drain_n_in   = cur_cnt;
                  drain_act_in = anc_pkg::ACT_FREE;
                  drain_mac_in = '0;
                  st_we        = 1'b1;
                  st_wdata     = anc_pkg::ST_FREE;
                  tv_wdata     = 1'b0;
                  cnt_wdata    = '0;
                  slot_v_in[0] = pkt_ff;
                  slot_v_in[2] = 1'b1;
                  slot_in[2]   = '{act: anc_pkg::ACT_FAILED, mac: '0, ip: '0, src: '0,
                                   handle: '0};
               end else begin
                  er_we          = 1'b1;
                  er_wdata.ip    = addr_ff;
                  er_wdata.mac   = er_rd.mac;
                  er_wdata.rtime = cur_tv ? er_rd.rtime : now_ff;
                  st_we          = 1'b1;
                  st_wdata       = anc_pkg::ST_INCOMPLETE;
                  tv_wdata       = 1'b1;
                  cnt_wdata      = cur_cnt;
                  if (pkt_ff) begin
                     if (cur_cnt < CNT_W'(anc_pkg::QUEUE_DEPTH)) begin
                        hq_we     = 1'b1;
                        cnt_wdata = cur_cnt + 1'b1;
                     end else begin
                        slot_v_in[0] = 1'b1;
                     end
                  end
                  slot_v_in[1] = own_valid_ff;
                  slot_in[1]   = '{act: anc_pkg::ACT_REQUEST, mac: anc_pkg::BCAST_MAC,
                                   ip: addr_ff, src: own_ip_ff, handle: '0};
                  slot_v_in[2] = 1'b1;
                  slot_in[2]   = '{act: anc_pkg::ACT_PENDING, mac: '0, ip: '0, src: '0,
                                   handle: '0};
               end
            end else begin
               // Received packet or learn: store the mapping and release held packets if the
               // entry was waiting for it.
               if (ok_ff) begin
                  er_we          = 1'b1;
                  er_wdata.ip    = addr_ff;
                  er_wdata.mac   = hw_ff;
                  er_wdata.rtime = '0;
                  st_we          = 1'b1;
                  st_wdata       = anc_pkg::ST_REACHABLE;
                  tv_wdata       = 1'b0;
                  cnt_wdata      = '0;
                  drain_act_in   = anc_pkg::ACT_TRANSMIT;
                  drain_mac_in   = hw_ff;
                  if (hit_v_ff && (st_sel == anc_pkg::ST_INCOMPLETE)) begin
                     drain_n_in = cnt_sel;
                  end
               end
               if ((op_ff == anc_pkg::OP_RX) && reply_ok_ff) begin
                  slot_v_in[1] = 1'b1;
                  slot_in[1]   = '{act: anc_pkg::ACT_REPLY, mac: hw_ff, ip: addr_ff,
                                   src: tgt_ff, handle: '0};
               end
            end
         end

         S_DRD: begin
            if (k_ff == drain_n_ff) begin
               fsm_in = S_SLOT;
            end else begin
               fsm_in = S_DWT;
            end
         end

         S_DWT: begin
            out_res  = '{act: drain_act_ff, mac: drain_mac_ff, ip: '0, src: '0,
                         handle: 8'(hq_rdata)};
            out_last = ((k_ff + 1'b1) == drain_n_ff) && !(|slot_v_ff);
            if (out_free) begin
               out_load = 1'b1;
               k_in     = k_ff + 1'b1;
               fsm_in   = out_last ? S_IDLE : S_DRD;
            end
         end

         S_SLOT: begin
            if (!(|slot_v_ff)) begin
               fsm_in = S_IDLE;
            end else begin
               if (slot_v_ff[0]) begin
                  out_res  = slot_ff[0];
                  out_last = !slot_v_ff[1] && !slot_v_ff[2];
               end else if (slot_v_ff[1]) begin
                  out_res  = slot_ff[1];
                  out_last = !slot_v_ff[2];
               end else begin
                  out_res  = slot_ff[2];
                  out_last = 1'b1;
               end
               if (out_free) begin
                  out_load = 1'b1;
                  if (slot_v_ff[0]) begin
                     slot_v_in[0] = 1'b0;
                  end else if (slot_v_ff[1]) begin
                     slot_v_in[1] = 1'b0;
                  end else begin
                     slot_v_in[2] = 1'b0;
                  end
                  if (out_last) begin
                     fsm_in = S_IDLE;
                  end
               end
            end
         end

         default: begin
            fsm_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= S_IDLE;
         scan_cnt_ff  <= '0;
         cmp_v_ff     <= 1'b0;
         hit_v_ff     <= 1'b0;
         free_v_ff    <= 1'b0;
         reach_v_ff   <= 1'b0;
         ok_ff        <= 1'b0;
         k_ff         <= '0;
         drain_n_ff   <= '0;
         slot_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         own_ip_ff    <= '0;
         own_valid_ff <= 1'b0;
         own_mac_ff   <= '0;
         timeout_ff   <= anc_pkg::DEFAULT_TIMEOUT;
         for (int i = 0; i < anc_pkg::ENTRIES; i++) begin
            st_ff[i]  <= anc_pkg::ST_FREE;
            tv_ff[i]  <= 1'b0;
            cnt_ff[i] <= '0;
         end
      end else begin
         fsm_ff       <= fsm_in;
         scan_cnt_ff  <= scan_cnt_in;
         cmp_v_ff     <= cmp_v_in;
         hit_v_ff     <= hit_v_in;
         free_v_ff    <= free_v_in;
         reach_v_ff   <= reach_v_in;
         ok_ff        <= ok_in;
         k_ff         <= k_in;
         drain_n_ff   <= drain_n_in;
         slot_v_ff    <= slot_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (st_we) begin
            st_ff[e_ff]  <= st_wdata;
            tv_ff[e_ff]  <= tv_wdata;
            cnt_ff[e_ff] <= cnt_wdata;
         end
         if (csr_valid) begin
            case (csr_index)
               anc_pkg::REG_OWN_IP:       own_ip_ff    <= csr_wdata[31:0];
               anc_pkg::REG_OWN_IP_VALID: own_valid_ff <= csr_wdata[0];
               anc_pkg::REG_OWN_MAC:      own_mac_ff   <= csr_wdata;
               anc_pkg::REG_TIMEOUT_MS:   timeout_ff   <= csr_wdata[15:0];
               default:                   own_ip_ff    <= own_ip_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      reach_idx_ff <= reach_idx_in;
      e_ff         <= e_in;
      drain_act_ff <= drain_act_in;
      drain_mac_ff <= drain_mac_in;
      slot_ff      <= slot_in;
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      tgt_ff       <= tgt_in;
      now_ff       <= now_in;
      hw_ff        <= hw_in;
      pkt_ff       <= pkt_in;
      handle_ff    <= handle_in;
      reply_ok_ff  <= reply_ok_in;
      if (out_load) begin
         rsp_ff      <= out_res;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_ff.act;
   assign rsp_out_mac    = rsp_ff.mac;
   assign rsp_out_ip     = rsp_ff.ip;
   assign rsp_out_src_ip = rsp_ff.src;
   assign rsp_out_handle = rsp_ff.handle;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   // A new result is never loaded over one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("result loaded over a stalled result");

   // The release loop never reads past the held count.
   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == S_DWT) |-> (k_ff < drain_n_ff))
      else $error("held packet index beyond count");

   // An entry matched by the scan is still in use when the decision is made.
   a_hit_in_use: assert property (@(posedge clock) disable iff (reset)
      ((fsm_ff == S_DECIDE) && hit_v_ff) |-> (st_sel != anc_pkg::ST_FREE))
      else $error("matched entry is free");

   // A held queue never grows beyond its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == S_DECIDE) |=> (cnt_ff[e_ff] <= CNT_W'(anc_pkg::QUEUE_DEPTH)))
      else $error("held queue overflow");
`endif

endmodule
